// ===== rtl/prqs_pkg.sv =====
// Shared types, constants and a helper function for the priority ready-queue scheduler.
package prqs_pkg;

  localparam int CMD_W      = 2;
  localparam int TASK_W     = 5;
  localparam int PRIO_W     = 6;
  localparam int LINK_W     = TASK_W + 1;
  localparam int TASK_COUNT = 1 << TASK_W;
  localparam int PRIO_COUNT = 1 << PRIO_W;
  localparam int HALF_W     = PRIO_COUNT / 2;

  // Link value that marks the end of a list (one past the last task number).
  localparam logic [LINK_W-1:0] NO_TASK = LINK_W'(TASK_COUNT);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_READY = 2'd0,
    CMD_PREEMPT   = 2'd1,
    CMD_GET_READY = 2'd2,
    CMD_SCHEDULE  = 2'd3
  } cmd_t;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [4:0] {
    UOP_NOP,
    UOP_SET_TAIL_ARGS,
    UOP_SET_HEAD_ARGS,
    UOP_SET_UNL_CH,
    UOP_SET_UNL_TOP,
    UOP_SET_SW_UNL,
    UOP_SET_SEL_PRIO,
    UOP_SET_SEL_TOP,
    UOP_PT2,
    UOP_PT3,
    UOP_PH2,
    UOP_PH3,
    UOP_UL2,
    UOP_UL3,
    UOP_UL5,
    UOP_SEL2,
    UOP_FINISH
  } uop_t;

  typedef struct packed {
    uop_t uop;
  } ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic ch_valid;
    logic add_sel;
    logic run_is_chosen;
    logic sched_go;
    logic out_free;
  } stat_t;

  // Highest set priority in the map, zero when the map is empty.
  function automatic logic [PRIO_W-1:0] top_prio(input logic [PRIO_COUNT-1:0] m);
    logic [HALF_W-1:0] w;
    logic              hi;
    logic [PRIO_W-2:0] b;
    hi = |m[PRIO_COUNT-1:HALF_W];
    w  = hi ? m[PRIO_COUNT-1:HALF_W] : m[HALF_W-1:0];
    b  = '0;
    for (int i = 0; i < HALF_W; i++) begin
      if (w[i]) b = (PRIO_W-1)'(i);
    end
    return {hi, b};
  endfunction

endpackage

// ===== rtl/prqs_in_if.sv =====
// Command channel interface: one word carries a scheduler command and its arguments.
interface prqs_in_if;
  import prqs_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [TASK_W-1:0]   task_id;
  logic [PRIO_W-1:0]   priority_req;
  logic [TASK_W-1:0]   running_task;
  logic [PRIO_W-1:0]   running_priority;

  modport source (output valid, command, task_id, priority_req, running_task,
                  running_priority, input ready);
  modport sink (input valid, command, task_id, priority_req, running_task,
                running_priority, output ready);
endinterface

// ===== rtl/prqs_out_if.sv =====
// Result channel interface: one word carries the selected ready task and the switch flag.
interface prqs_out_if;
  import prqs_pkg::*;

  logic              valid;
  logic              ready;
  logic [TASK_W-1:0] ready_task;
  logic              ready_valid;
  logic [PRIO_W-1:0] ready_priority;
  logic              need_switch;

  modport source (output valid, ready_task, ready_valid, ready_priority, need_switch,
                  input ready);
  modport sink (input valid, ready_task, ready_valid, ready_priority, need_switch,
                output ready);
endinterface

// ===== rtl/prqs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module prqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/prqs_datapath.sv =====
// Datapath: list memories, priority map, selection and result registers.
module prqs_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  prqs_pkg::ctl_t            ctl,
  input  logic [prqs_pkg::CMD_W-1:0]  in_command,
  input  logic [prqs_pkg::TASK_W-1:0] in_task_id,
  input  logic [prqs_pkg::PRIO_W-1:0] in_priority_req,
  input  logic [prqs_pkg::TASK_W-1:0] in_running_task,
  input  logic [prqs_pkg::PRIO_W-1:0] in_running_priority,
  output prqs_pkg::stat_t           stat,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [prqs_pkg::TASK_W-1:0] out_ready_task,
  output logic                      out_ready_valid,
  output logic [prqs_pkg::PRIO_W-1:0] out_ready_priority,
  output logic                      out_need_switch
);
  import prqs_pkg::*;

  // Latched command word.
  cmd_t              cmd_r;
  logic [TASK_W-1:0] task_r, run_r;
  logic [PRIO_W-1:0] prio_r, run_prio_r;

  // Selection and scratch registers.
  logic [TASK_W-1:0] ch_task_r;
  logic              ch_valid_r;
  logic [PRIO_W-1:0] ch_prio_r;
  logic              sw_r;
  logic [PRIO_W-1:0] top_r;
  logic [TASK_W-1:0] cur_t_r;
  logic [PRIO_W-1:0] cur_p_r;
  logic [LINK_W-1:0] tl_r, h_r, n_r, pv_r;

  logic [PRIO_COUNT-1:0] map_r;
  logic [PRIO_COUNT-1:0] head_vld_r, tail_vld_r;
  logic                  hrv_r, trv_r;

  logic                  out_valid_r;
  logic [TASK_W-1:0]     out_task_r;
  logic                  out_rv_r;
  logic [PRIO_W-1:0]     out_prio_r;
  logic                  out_sw_r;

  // Memory ports.
  logic              head_we, tail_we, next_we, prev_we;
  logic [LINK_W-1:0] head_wd, tail_wd, next_wd, prev_wd;
  logic [TASK_W-1:0] next_wa, prev_wa;
  logic [LINK_W-1:0] head_q, tail_q, next_q, prev_q;
  logic [LINK_W-1:0] head_val, tail_val;
  logic [PRIO_W-1:0] top_now;

  prqs_ram #(.WIDTH(LINK_W), .DEPTH(PRIO_COUNT)) u_head (
    .clk(clk), .we(head_we), .waddr(cur_p_r), .wdata(head_wd), .raddr(cur_p_r),
    .rdata(head_q));
  prqs_ram #(.WIDTH(LINK_W), .DEPTH(PRIO_COUNT)) u_tail (
    .clk(clk), .we(tail_we), .waddr(cur_p_r), .wdata(tail_wd), .raddr(cur_p_r),
    .rdata(tail_q));
  prqs_ram #(.WIDTH(LINK_W), .DEPTH(TASK_COUNT)) u_next (
    .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd), .raddr(cur_t_r),
    .rdata(next_q));
  prqs_ram #(.WIDTH(LINK_W), .DEPTH(TASK_COUNT)) u_prev (
    .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd), .raddr(cur_t_r),
    .rdata(prev_q));

  // An entry never written since reset reads as an empty list.
  assign head_val = hrv_r ? head_q : NO_TASK;
  assign tail_val = trv_r ? tail_q : NO_TASK;
  assign top_now  = top_prio(map_r);

  // Memory write decode for each link-update step.
  always_comb begin
    head_we = 1'b0; head_wd = NO_TASK;
    tail_we = 1'b0; tail_wd = NO_TASK;
    next_we = 1'b0; next_wa = cur_t_r; next_wd = NO_TASK;
    prev_we = 1'b0; prev_wa = cur_t_r; prev_wd = NO_TASK;
    case (ctl.uop)
      UOP_PT2: begin
        next_we = 1'b1;
      end
      UOP_PT3: begin
        prev_we = 1'b1;
        prev_wd = tl_r;
        if (!tl_r[LINK_W-1]) begin
          next_we = 1'b1;
          next_wa = tl_r[TASK_W-1:0];
          next_wd = {1'b0, cur_t_r};
        end else begin
          head_we = 1'b1;
          head_wd = {1'b0, cur_t_r};
        end
        tail_we = 1'b1;
        tail_wd = {1'b0, cur_t_r};
      end
      UOP_PH2: begin
        prev_we = 1'b1;
        next_we = 1'b1;
        next_wd = head_val;
        head_we = 1'b1;
        head_wd = {1'b0, cur_t_r};
      end
      UOP_PH3: begin
        if (!h_r[LINK_W-1]) begin
          prev_we = 1'b1;
          prev_wa = h_r[TASK_W-1:0];
          prev_wd = {1'b0, cur_t_r};
        end else begin
          tail_we = 1'b1;
          tail_wd = {1'b0, cur_t_r};
        end
      end
      UOP_UL2: begin
        if (!next_q[LINK_W-1]) begin
          prev_we = 1'b1;
          prev_wa = next_q[TASK_W-1:0];
          prev_wd = prev_q;
        end else begin
          tail_we = 1'b1;
          tail_wd = prev_q;
        end
      end
      UOP_UL3: begin
        if (!pv_r[LINK_W-1]) begin
          next_we = 1'b1;
          next_wa = pv_r[TASK_W-1:0];
          next_wd = n_r;
        end else begin
          head_we = 1'b1;
          head_wd = n_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state: selection, priority map, written-entry flags and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_task_r   <= '0;
      ch_valid_r  <= 1'b0;
      ch_prio_r   <= '0;
      map_r       <= '0;
      head_vld_r  <= '0;
      tail_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (head_we) head_vld_r[cur_p_r] <= 1'b1;
      if (tail_we) tail_vld_r[cur_p_r] <= 1'b1;
      // A new result word is loaded only once the previous one has gone.
      if (ctl.uop == UOP_FINISH) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (ctl.uop) inside
        UOP_PT3, UOP_PH2: map_r[cur_p_r] <= 1'b1;
        UOP_UL5: begin
          if (head_val[LINK_W-1]) map_r[cur_p_r] <= 1'b0;
        end
        UOP_SEL2: begin
          if (!head_val[LINK_W-1]) begin
            ch_task_r  <= head_val[TASK_W-1:0];
            ch_prio_r  <= cur_p_r;
            ch_valid_r <= 1'b1;
          end else begin
            ch_task_r  <= '0;
            ch_prio_r  <= '0;
            ch_valid_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload and scratch registers.
  always_ff @(posedge clk) begin
    hrv_r <= head_vld_r[cur_p_r];
    trv_r <= tail_vld_r[cur_p_r];
    if (accept) begin
      cmd_r      <= cmd_t'(in_command);
      task_r     <= in_task_id;
      prio_r     <= in_priority_req;
      run_r      <= in_running_task;
      run_prio_r <= in_running_priority;
      sw_r       <= 1'b0;
    end
    case (ctl.uop)
      UOP_SET_TAIL_ARGS: begin
        cur_t_r <= task_r;
        cur_p_r <= prio_r;
      end
      UOP_SET_HEAD_ARGS: begin
        cur_t_r <= run_r;
        cur_p_r <= run_prio_r;
      end
      UOP_SET_UNL_CH: begin
        cur_t_r <= ch_task_r;
        cur_p_r <= ch_prio_r;
      end
      UOP_SET_UNL_TOP: begin
        cur_t_r <= ch_task_r;
        cur_p_r <= top_r;
      end
      UOP_SET_SW_UNL: begin
        cur_t_r <= ch_task_r;
        cur_p_r <= top_r;
        sw_r    <= 1'b1;
      end
      UOP_SET_SEL_PRIO: cur_p_r <= prio_r;
      UOP_SET_SEL_TOP: begin
        top_r   <= top_now;
        cur_p_r <= top_now;
      end
      UOP_PT2: tl_r <= tail_val;
      UOP_PH2: h_r <= head_val;
      UOP_UL2: begin
        n_r  <= next_q;
        pv_r <= prev_q;
      end
      UOP_FINISH: begin
        out_task_r <= ch_task_r;
        out_rv_r   <= ch_valid_r;
        out_prio_r <= ch_prio_r;
        out_sw_r   <= sw_r;
      end
      default: begin
      end
    endcase
  end

  // Status toward the controller.
  assign stat.cmd           = cmd_r;
  assign stat.ch_valid      = ch_valid_r;
  assign stat.add_sel       = !ch_valid_r || (prio_r > ch_prio_r);
  assign stat.run_is_chosen = (ch_task_r == run_r);
  assign stat.sched_go      = ch_valid_r && (ch_prio_r > run_prio_r);
  assign stat.out_free      = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_ready_task     = out_task_r;
  assign out_ready_valid    = out_rv_r;
  assign out_ready_priority = out_prio_r;
  assign out_need_switch    = out_sw_r;

endmodule

// ===== rtl/prqs_ctrl.sv =====
// Controller: sequences the list operations of each command.
module prqs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  prqs_pkg::stat_t stat,
  output prqs_pkg::ctl_t  ctl,
  output logic            in_ready
);
  import prqs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP,
    S_PT_SET, S_PT_RD, S_PT2, S_PT3, S_A_DEC,
    S_PH_SET, S_PH_RD, S_PH2, S_PH3,
    S_UL_CH_SET, S_UL_TOP_SET, S_SW_SET, S_UL_RD, S_UL2, S_UL3, S_UL4, S_UL5,
    S_SEL_PRIO_SET, S_SEL_TOP_SET, S_SEL_RD, S_SEL2, S_SEL_DEC,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  // Next state and operation for the datapath.
  always_comb begin
    state_nxt = state_r;
    ctl.uop   = UOP_NOP;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_DISP;
      S_DISP: begin
        unique case (stat.cmd)
          CMD_ADD_READY: state_nxt = S_PT_SET;
          CMD_PREEMPT:   state_nxt = stat.ch_valid ? S_UL_CH_SET : S_PH_SET;
          default:       state_nxt = S_SEL_TOP_SET;
        endcase
      end
      S_PT_SET: begin
        ctl.uop = UOP_SET_TAIL_ARGS;
        state_nxt = S_PT_RD;
      end
      S_PT_RD: state_nxt = S_PT2;
      S_PT2: begin
        ctl.uop = UOP_PT2;
        state_nxt = S_PT3;
      end
      S_PT3: begin
        ctl.uop = UOP_PT3;
        state_nxt = S_A_DEC;
      end
      S_A_DEC: begin
        if (stat.add_sel) state_nxt = S_SEL_PRIO_SET;
        else if (stat.run_is_chosen) state_nxt = S_SEL_TOP_SET;
        else state_nxt = S_FIN;
      end
      S_PH_SET: begin
        ctl.uop = UOP_SET_HEAD_ARGS;
        state_nxt = S_PH_RD;
      end
      S_PH_RD: state_nxt = S_PH2;
      S_PH2: begin
        ctl.uop = UOP_PH2;
        state_nxt = S_PH3;
      end
      S_PH3: begin
        ctl.uop = UOP_PH3;
        state_nxt = S_FIN;
      end
      S_UL_CH_SET: begin
        ctl.uop = UOP_SET_UNL_CH;
        state_nxt = S_UL_RD;
      end
      S_UL_TOP_SET: begin
        ctl.uop = UOP_SET_UNL_TOP;
        state_nxt = S_UL_RD;
      end
      S_SW_SET: begin
        ctl.uop = UOP_SET_SW_UNL;
        state_nxt = S_UL_RD;
      end
      S_UL_RD: state_nxt = S_UL2;
      S_UL2: begin
        ctl.uop = UOP_UL2;
        state_nxt = S_UL3;
      end
      S_UL3: begin
        ctl.uop = UOP_UL3;
        state_nxt = S_UL4;
      end
      S_UL4: state_nxt = S_UL5;
      S_UL5: begin
        ctl.uop = UOP_UL5;
        state_nxt = (stat.cmd == CMD_GET_READY) ? S_FIN : S_PH_SET;
      end
      S_SEL_PRIO_SET: begin
        ctl.uop = UOP_SET_SEL_PRIO;
        state_nxt = S_SEL_RD;
      end
      S_SEL_TOP_SET: begin
        ctl.uop = UOP_SET_SEL_TOP;
        state_nxt = S_SEL_RD;
      end
      S_SEL_RD: state_nxt = S_SEL2;
      S_SEL2: begin
        ctl.uop = UOP_SEL2;
        state_nxt = S_SEL_DEC;
      end
      S_SEL_DEC: begin
        if (stat.cmd == CMD_GET_READY && stat.ch_valid) state_nxt = S_UL_TOP_SET;
        else if (stat.cmd == CMD_SCHEDULE && stat.sched_go) state_nxt = S_SW_SET;
        else state_nxt = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          ctl.uop = UOP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

// ===== rtl/priority_ready_queue_scheduler.sv =====
// Top level of the priority ready-queue scheduler.
//
//   Channel   Dir  Handshake     Word
//   in_port   in   valid/ready   command, task_id, priority_req, running_task, running_priority
//   out_port  out  valid/ready   ready_task, ready_valid, ready_priority, need_switch
//
// One command at a time. Each command runs as a sequence of dependent accesses to the head,
// tail and link memories, each of which has one write port and one registered read port.
// Schedule with a switch is the longest path: select, unlink, push to head.
// rst_n is synchronous; all lists come up empty and no task is selected.
// A result held by a stalled sink delays only the end of the next command.
module priority_ready_queue_scheduler (
  input logic        clk,
  input logic        rst_n,
  prqs_in_if.sink    in_port,
  prqs_out_if.source out_port
);
  import prqs_pkg::*;

  ctl_t  ctl;
  stat_t stat;
  logic  accept;

  assign accept = in_port.valid && in_port.ready;

  prqs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .accept(accept), .stat(stat), .ctl(ctl),
    .in_ready(in_port.ready));

  prqs_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .accept(accept), .ctl(ctl),
    .in_command(in_port.command), .in_task_id(in_port.task_id),
    .in_priority_req(in_port.priority_req), .in_running_task(in_port.running_task),
    .in_running_priority(in_port.running_priority),
    .stat(stat),
    .out_valid(out_port.valid), .out_ready(out_port.ready),
    .out_ready_task(out_port.ready_task), .out_ready_valid(out_port.ready_valid),
    .out_ready_priority(out_port.ready_priority),
    .out_need_switch(out_port.need_switch));

  // A word without a selection carries zero task and priority.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_port.valid |-> (out_port.ready_valid ||
                        (out_port.ready_task == '0 && out_port.ready_priority == '0)))
    else $error("result without selection carries nonzero fields");

  // A switch is only flagged when a task is selected.
  a_switch_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_port.valid && out_port.need_switch |-> out_port.ready_valid)
    else $error("switch flagged without selected task");

  // After a command is taken the block is busy for the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_port.ready)
    else $error("command accepted while busy");

endmodule
